@@ hw/rtl/path_point_filter_resampler_defines.svh @@
// Assertion macros used by the checker file of the path point resampler.
`ifndef PATH_POINT_FILTER_RESAMPLER_DEFINES_SVH
`define PATH_POINT_FILTER_RESAMPLER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PPFR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PPFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/ppfr_pkg.sv @@
// Shared constants and types of the path point filter and resampler.
package ppfr_pkg;

  // Largest number of points one segment is split into.
  localparam int unsigned MAX_SUBDIV = 31;

  // Register reset values and register indexes.
  localparam logic [23:0] MIN_KEEP_RST = 24'd200;
  localparam logic [23:0] SPACING_RST  = 24'd400;
  localparam logic        CFG_MIN_KEEP = 1'b0;
  localparam logic        CFG_SPACING  = 1'b1;

  // Largest Q1.15 value.
  localparam logic [15:0] Q_ONE = 16'h7FFF;

  typedef enum logic [0:0] {
    OP_DIV,
    OP_SQRT
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FILT,
    ST_FCMP,
    ST_P2,
    ST_KEEP,
    ST_SMUL,
    ST_LQ,
    ST_WDIV,
    ST_WSQ,
    ST_MDIV,
    ST_MSQ,
    ST_RSEL,
    ST_RSQ,
    ST_RDIV,
    ST_ADIV,
    ST_EMIT,
    ST_AFTER,
    ST_FINAL,
    ST_WRAP
  } state_e;

endpackage

@@ hw/rtl/ppfr_divsqrt.sv @@
// Iterative shift-subtract unit: 64-bit divide or 64-bit integer square root.
module ppfr_divsqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ppfr_pkg::unit_req_t req_i,
  input  logic [63:0]         num_i,
  input  logic [63:0]         den_i,
  output logic                done_o,
  output logic [63:0]         res_o,
  output logic [63:0]         rem_o
);

  logic [63:0]        work_q, den_q, quo_q, rem_q;
  logic [6:0]         cnt_q;
  logic               busy_q, done_q;
  ppfr_pkg::unit_op_e op_q;

  logic [65:0] x, y;
  logic [66:0] diff;
  logic        ge;

  // One shared subtractor serves both the divide and the root step.
  always_comb begin
    if (op_q == ppfr_pkg::OP_DIV) begin
      x = {1'b0, rem_q, work_q[63]};
      y = {2'b00, den_q};
    end else begin
      x = {rem_q, work_q[63:62]};
      y = {quo_q, 2'b01};
    end
    diff = {1'b0, x} - {1'b0, y};
    ge   = !diff[66];
  end

  // Control: iteration counter and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ppfr_pkg::OP_DIV;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        op_q   <= req_i.op;
        cnt_q  <= (req_i.op == ppfr_pkg::OP_DIV) ? 7'd64 : 7'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shifting operand, partial remainder and result.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= num_i;
      den_q  <= den_i;
      quo_q  <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      if (op_q == ppfr_pkg::OP_DIV) begin
        work_q <= {work_q[62:0], 1'b0};
        rem_q  <= ge ? diff[63:0] : x[63:0];
      end else begin
        work_q <= {work_q[61:0], 2'b00};
        rem_q  <= ge ? diff[63:0] : x[63:0];
      end
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign res_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

@@ hw/rtl/path_point_filter_resampler.sv @@
// Path point filter and resampler: top level with sequencer and datapath.
// An input word that keeps no point stalls the input through the ST_P2 step, after
// the ST_FILT and ST_FCMP distance test if one runs. A kept point with a previous
// kept point also runs the shared divide/root unit and then emits its output
// words, and a stalled output holds the block until each word is taken.
// Reset clears all control state and loads the register defaults 200 and 400.
module path_point_filter_resampler #(
  parameter int unsigned MaxSubdiv = ppfr_pkg::MAX_SUBDIV
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] px_i,
  input  logic signed [23:0] py_i,
  input  logic signed [23:0] pz_i,
  input  logic               path_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] out_x_o,
  output logic signed [23:0] out_y_o,
  output logic signed [23:0] out_z_o,
  output logic signed [15:0] quat_z_o,
  output logic signed [15:0] quat_w_o,
  output logic               run_last_o,
  output logic               path_done_o
);

  localparam int unsigned KW = (MaxSubdiv < 2) ? 1 : $clog2(MaxSubdiv + 1);
  localparam int unsigned DW = $clog2(MaxSubdiv + 2);
  localparam logic [KW-1:0] RMax = KW'(MaxSubdiv);

  ppfr_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [23:0] min_keep_q, spacing_q;

  // Control state.
  logic          pend_valid_q, kept_valid_q, phase2_q, had_q, issued_q, in_last_q;
  logic [2:0]    mc_q;
  logic [KW-1:0] r_q, k_q;
  logic [1:0]    ax_q;
  logic          out_valid_q;

  // Payload registers.
  logic signed [23:0] in_q [3];
  logic signed [23:0] pend_q [3];
  logic signed [23:0] kept_q [3];
  logic [49:0]        prod_q;
  logic [51:0]        acc_q;
  logic [50:0]        s_q;
  logic [47:0]        thr_q;
  logic [32:0]        lq_q;
  logic [63:0]        tmp_q;
  logic [15:0]        qz_q, qw_q;
  logic [25:0]        qd_q [3];
  logic [25:0]        qacc_q [3];
  logic [DW-1:0]      rd_q [3];
  logic [DW-1:0]      racc_q [3];
  logic [23:0]        ox_q, oy_q, oz_q;
  logic [15:0]        oqz_q, oqw_q;
  logic               orl_q, odone_q;

  // Unit interface.
  ppfr_pkg::unit_req_t u_req;
  logic [63:0]         u_num, u_den, u_res, u_rem;
  logic                u_done;

  ppfr_divsqrt u_divsqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .num_i  (u_num),
    .den_i  (u_den),
    .done_o (u_done),
    .res_o  (u_res),
    .rem_o  (u_rem)
  );

  // Segment end point and coordinate differences.
  logic signed [23:0] seg_p [3];
  logic signed [25:0] seg_d [3];
  logic signed [25:0] filt_d [3];
  logic [25:0]        seg_abs [3];
  logic [25:0]        pt [3];
  logic [DW:0]        rsum [3];

  logic [23:0]        sp_eff;
  logic [DW-1:0]      div_w;
  logic signed [25:0] mul_op;
  logic signed [51:0] mul_full;
  logic [25:0]        ndx;
  logic [63:0]        xk128, num_w, num_m;
  logic [15:0]        sat_res;
  logic [KW-1:0]      r_sat;
  logic               accept, out_free, out_load, unit_st;
  logic [23:0]        ld_x, ld_y, ld_z;
  logic [15:0]        ld_qz, ld_qw;
  logic               ld_rl, ld_done;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      seg_p[a]   = phase2_q ? in_q[a] : pend_q[a];
      seg_d[a]   = {{2{seg_p[a][23]}}, seg_p[a]} - {{2{kept_q[a][23]}}, kept_q[a]};
      filt_d[a]  = {{2{in_q[a][23]}}, in_q[a]} - {{2{pend_q[a][23]}}, pend_q[a]};
      seg_abs[a] = seg_d[a][25] ? 26'(-seg_d[a]) : 26'(seg_d[a]);
      pt[a]      = {{2{kept_q[a][23]}}, kept_q[a]}
                 + (seg_d[a][25] ? 26'(-qacc_q[a]) : qacc_q[a]);
      rsum[a]    = {1'b0, racc_q[a]} + {1'b0, rd_q[a]};
    end
  end

  assign sp_eff = (spacing_q == 24'd0) ? 24'd1 : spacing_q;
  assign div_w  = DW'(r_q) + DW'(1);

  // Squaring operand: three differences, then the threshold.
  always_comb begin
    if (mc_q == 3'd3) begin
      mul_op = {2'b00, (state_q == ppfr_pkg::ST_FILT) ? min_keep_q : sp_eff};
    end else if (state_q == ppfr_pkg::ST_FILT) begin
      mul_op = filt_d[mc_q[1:0]];
    end else begin
      mul_op = seg_d[mc_q[1:0]];
    end
    mul_full = mul_op * mul_op;
  end

  // Yaw numerators: Lq plus or minus 128 times the start-minus-end x.
  assign ndx   = 26'(-seg_d[0]);
  assign xk128 = {{31{ndx[25]}}, ndx, 7'b0};
  assign num_w = {31'b0, lq_q} + xk128;
  assign num_m = {31'b0, lq_q} - xk128;

  assign sat_res = (u_res > 64'd32767) ? ppfr_pkg::Q_ONE : u_res[15:0];
  assign r_sat   = (u_res > 64'(MaxSubdiv)) ? RMax : u_res[KW-1:0];

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Unit operand selection.
  always_comb begin
    unit_st  = 1'b1;
    u_req.op = ppfr_pkg::OP_SQRT;
    u_num    = tmp_q;
    u_den    = {40'b0, sp_eff};
    case (state_q)
      ppfr_pkg::ST_LQ:   u_num = {s_q[49:0], 14'b0};
      ppfr_pkg::ST_WDIV: begin
        u_req.op = ppfr_pkg::OP_DIV;
        u_num    = {num_w[34:0], 29'b0};
        u_den    = {31'b0, lq_q};
      end
      ppfr_pkg::ST_WSQ:  u_num = tmp_q;
      ppfr_pkg::ST_MDIV: begin
        u_req.op = ppfr_pkg::OP_DIV;
        u_num    = {num_m[34:0], 29'b0};
        u_den    = {31'b0, lq_q};
      end
      ppfr_pkg::ST_MSQ:  u_num = tmp_q;
      ppfr_pkg::ST_RSQ:  u_num = {12'b0, acc_q};
      ppfr_pkg::ST_RDIV: u_req.op = ppfr_pkg::OP_DIV;
      ppfr_pkg::ST_ADIV: begin
        u_req.op = ppfr_pkg::OP_DIV;
        u_num    = {38'b0, seg_abs[ax_q]};
        u_den    = {(64 - DW)'(0), div_w};
      end
      default: unit_st = 1'b0;
    endcase
    u_req.start = unit_st && !issued_q;
  end

  // Next state and output word selection.
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    ld_x     = pt[0][23:0];
    ld_y     = pt[1][23:0];
    ld_z     = pt[2][23:0];
    ld_qz    = qz_q;
    ld_qw    = qw_q;
    ld_rl    = (k_q == r_q - KW'(1)) && !phase2_q && !in_last_q;
    ld_done  = 1'b0;
    case (state_q)
      ppfr_pkg::ST_IDLE:
        if (accept) state_d = path_end_i && !pend_valid_q ? ppfr_pkg::ST_P2 :
                              (pend_valid_q ? ppfr_pkg::ST_FILT : ppfr_pkg::ST_P2);
      ppfr_pkg::ST_FILT: if (mc_q == 3'd4) state_d = ppfr_pkg::ST_FCMP;
      ppfr_pkg::ST_FCMP:
        state_d = (acc_q > {4'b0, thr_q}) ? ppfr_pkg::ST_KEEP : ppfr_pkg::ST_P2;
      ppfr_pkg::ST_P2:
        if (in_last_q) state_d = ppfr_pkg::ST_KEEP;
        else state_d = ppfr_pkg::ST_IDLE;
      ppfr_pkg::ST_KEEP:
        state_d = kept_valid_q ? ppfr_pkg::ST_SMUL : ppfr_pkg::ST_AFTER;
      ppfr_pkg::ST_SMUL: if (mc_q == 3'd4) state_d = ppfr_pkg::ST_LQ;
      ppfr_pkg::ST_LQ:
        if (u_done) state_d = (u_res == 64'd0) ? ppfr_pkg::ST_RSEL : ppfr_pkg::ST_WDIV;
      ppfr_pkg::ST_WDIV: if (u_done) state_d = ppfr_pkg::ST_WSQ;
      ppfr_pkg::ST_WSQ:  if (u_done) state_d = ppfr_pkg::ST_MDIV;
      ppfr_pkg::ST_MDIV: if (u_done) state_d = ppfr_pkg::ST_MSQ;
      ppfr_pkg::ST_MSQ:  if (u_done) state_d = ppfr_pkg::ST_RSEL;
      ppfr_pkg::ST_RSEL:
        state_d = (acc_q > {4'b0, thr_q}) ? ppfr_pkg::ST_RSQ : ppfr_pkg::ST_ADIV;
      ppfr_pkg::ST_RSQ:  if (u_done) state_d = ppfr_pkg::ST_RDIV;
      ppfr_pkg::ST_RDIV: if (u_done) state_d = ppfr_pkg::ST_ADIV;
      ppfr_pkg::ST_ADIV: if (u_done && ax_q == 2'd2) state_d = ppfr_pkg::ST_EMIT;
      ppfr_pkg::ST_EMIT:
        if (out_free) begin
          out_load = 1'b1;
          if (k_q == r_q - KW'(1)) state_d = ppfr_pkg::ST_AFTER;
        end
      ppfr_pkg::ST_AFTER:
        if (!phase2_q) state_d = ppfr_pkg::ST_P2;
        else state_d = had_q ? ppfr_pkg::ST_FINAL : ppfr_pkg::ST_WRAP;
      ppfr_pkg::ST_FINAL: begin
        ld_x    = in_q[0];
        ld_y    = in_q[1];
        ld_z    = in_q[2];
        ld_rl   = 1'b1;
        ld_done = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ppfr_pkg::ST_WRAP;
        end
      end
      ppfr_pkg::ST_WRAP: state_d = ppfr_pkg::ST_IDLE;
      default: state_d = ppfr_pkg::ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppfr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_keep_q <= ppfr_pkg::MIN_KEEP_RST;
      spacing_q  <= ppfr_pkg::SPACING_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == ppfr_pkg::CFG_MIN_KEEP) min_keep_q <= cfg_wdata_i;
      else spacing_q <= cfg_wdata_i;
    end
  end

  // Control registers: path flags, step counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      kept_valid_q <= 1'b0;
      phase2_q     <= 1'b0;
      had_q        <= 1'b0;
      issued_q     <= 1'b0;
      in_last_q    <= 1'b0;
      mc_q         <= '0;
      r_q          <= KW'(1);
      k_q          <= '0;
      ax_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (u_req.start) issued_q <= 1'b1;
      else if (u_done) issued_q <= 1'b0;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        ppfr_pkg::ST_IDLE:
          if (accept) begin
            in_last_q <= path_end_i;
            mc_q      <= '0;
            phase2_q  <= 1'b0;
          end
        ppfr_pkg::ST_FILT, ppfr_pkg::ST_SMUL: mc_q <= (mc_q == 3'd4) ? 3'd0 : mc_q + 3'd1;
        ppfr_pkg::ST_P2:
          if (in_last_q) begin
            had_q    <= kept_valid_q;
            phase2_q <= 1'b1;
          end else begin
            pend_valid_q <= 1'b1;
          end
        ppfr_pkg::ST_KEEP: mc_q <= '0;
        ppfr_pkg::ST_RSEL: begin
          r_q  <= KW'(1);
          ax_q <= '0;
        end
        ppfr_pkg::ST_RDIV: if (u_done) r_q <= r_sat;
        ppfr_pkg::ST_ADIV:
          if (u_done) begin
            ax_q <= ax_q + 2'd1;
            k_q  <= '0;
          end
        ppfr_pkg::ST_EMIT: if (out_free) k_q <= k_q + KW'(1);
        ppfr_pkg::ST_AFTER: kept_valid_q <= 1'b1;
        ppfr_pkg::ST_WRAP: begin
          pend_valid_q <= 1'b0;
          kept_valid_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[49:0];
    if (out_load) begin
      ox_q    <= ld_x;
      oy_q    <= ld_y;
      oz_q    <= ld_z;
      oqz_q   <= ld_qz;
      oqw_q   <= ld_qw;
      orl_q   <= ld_rl;
      odone_q <= ld_done;
    end
    case (state_q)
      ppfr_pkg::ST_IDLE:
        if (accept) begin
          in_q[0] <= px_i;
          in_q[1] <= py_i;
          in_q[2] <= pz_i;
        end
      ppfr_pkg::ST_FILT, ppfr_pkg::ST_SMUL:
        case (mc_q)
          3'd1: acc_q <= {2'b0, prod_q};
          3'd2: begin
            acc_q <= acc_q + {2'b0, prod_q};
            s_q   <= 51'(acc_q + {2'b0, prod_q});
          end
          3'd3: acc_q <= acc_q + {2'b0, prod_q};
          3'd4: thr_q <= prod_q[47:0];
          default: ;
        endcase
      ppfr_pkg::ST_P2:
        if (!in_last_q) pend_q <= in_q;
      ppfr_pkg::ST_LQ:
        if (u_done) begin
          lq_q <= u_res[32:0];
          qz_q <= 16'd0;
          qw_q <= ppfr_pkg::Q_ONE;
        end
      ppfr_pkg::ST_WDIV, ppfr_pkg::ST_MDIV, ppfr_pkg::ST_RSQ:
        if (u_done) tmp_q <= u_res;
      ppfr_pkg::ST_WSQ: if (u_done) qw_q <= sat_res;
      ppfr_pkg::ST_MSQ:
        if (u_done) qz_q <= (seg_d[1] > 26'sd0) ? 16'(-sat_res) : sat_res;
      ppfr_pkg::ST_ADIV:
        if (u_done) begin
          qd_q[ax_q]   <= u_res[25:0];
          rd_q[ax_q]   <= u_rem[DW-1:0];
          qacc_q[ax_q] <= '0;
          racc_q[ax_q] <= '0;
        end
      ppfr_pkg::ST_EMIT:
        if (out_free) begin
          for (int a = 0; a < 3; a++) begin
            if (rsum[a] >= {1'b0, div_w}) begin
              racc_q[a] <= DW'(rsum[a] - {1'b0, div_w});
              qacc_q[a] <= qacc_q[a] + qd_q[a] + 26'd1;
            end else begin
              racc_q[a] <= rsum[a][DW-1:0];
              qacc_q[a] <= qacc_q[a] + qd_q[a];
            end
          end
        end
      ppfr_pkg::ST_AFTER: kept_q <= seg_p;
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ppfr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign quat_z_o    = oqz_q;
  assign quat_w_o    = oqw_q;
  assign run_last_o  = orl_q;
  assign path_done_o = odone_q;

endmodule

@@ hw/rtl/ppfr_checker.sv @@
// Port-level checker for the path point resampler and its bind statement.
`include "path_point_filter_resampler_defines.svh"

module ppfr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] quat_w_o,
  input logic               run_last_o,
  input logic               path_done_o
);

  // A stalled output word stays offered.
  `PPFR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o, "output word dropped")

  // An accepted input word occupies the block for at least the next cycle.
  `PPFR_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "no busy after accept")

  // The final point of a path is always the last word of its input.
  `PPFR_ASSERT_IMPL(a_done_last, out_valid_o && path_done_o, run_last_o, "path_done without run_last")

  // The half-yaw cosine comes from a square root and is never negative.
  `PPFR_ASSERT_IMPL(a_qw_pos, out_valid_o, !quat_w_o[15], "negative quat_w")

endmodule

bind path_point_filter_resampler ppfr_checker u_ppfr_checker (.*);
